@@ rtl/occupancy_grid_scan_update_defines.svh @@
// Assertion macros shared by the occupancy grid scan update block.
`ifndef OCCUPANCY_GRID_SCAN_UPDATE_DEFINES_SVH
`define OCCUPANCY_GRID_SCAN_UPDATE_DEFINES_SVH
// Asserts that an antecedent implies a consequent in the next cycle.
`define OGSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
// Asserts that an antecedent implies a consequent in the same cycle.
`define OGSU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/ogsu_pkg.sv @@
// Package with the constants, types and helper functions of the occupancy grid block.
package ogsu_pkg;
  localparam int GridRowsDef = 256;
  localparam int GridColsDef = 256;
  localparam int BeamCountDef = 360;
  localparam int CordicSteps = 15;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_POSE = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [2:0] REG_FREE = 3'd0;
  localparam logic [2:0] REG_OCC = 3'd1;
  localparam logic [2:0] REG_PRIOR = 3'd2;
  localparam logic [2:0] REG_HALF = 3'd3;
  localparam logic [2:0] REG_OCOL = 3'd4;
  localparam logic [2:0] REG_OROW = 3'd5;

  typedef struct packed {
    logic clear_start;
    logic walk_start;
    logic read_start;
  } ogsu_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic walk_done;
    logic read_done;
  } ogsu_stat_t;

  function automatic logic [15:0] atan_entry(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0: v = 16'd8192;
      4'd1: v = 16'd4836;
      4'd2: v = 16'd2555;
      4'd3: v = 16'd1297;
      4'd4: v = 16'd651;
      4'd5: v = 16'd326;
      4'd6: v = 16'd163;
      4'd7: v = 16'd81;
      4'd8: v = 16'd41;
      4'd9: v = 16'd20;
      4'd10: v = 16'd10;
      4'd11: v = 16'd5;
      4'd12: v = 16'd3;
      4'd13: v = 16'd1;
      4'd14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = -16'sh8000;
    else r = v[15:0];
    return r;
  endfunction
endpackage

@@ rtl/ogsu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ogsu_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/ogsu_ctrl.sv @@
// Controller state machine that sequences clearing, map updates and cell reads.
module ogsu_ctrl import ogsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  input  logic       out_full,
  input  logic       out_take,
  input  ogsu_stat_t stat,
  output ogsu_cmd_t  cmd,
  output logic       accept,
  output logic       finish_now,
  output logic       busy
);
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_POST  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   started;
  logic   started_next;

  assign busy = (state != ST_IDLE);
  assign accept = (state == ST_IDLE) && in_valid && (!out_full || out_take);

  always_comb begin
    state_next = state;
    started_next = started;
    cmd = '0;
    finish_now = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (!started) begin
          cmd.clear_start = 1'b1;
          started_next = 1'b1;
        end else if (stat.clear_done) begin
          state_next = ST_IDLE;
          started_next = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_UPDATE: begin
              cmd.walk_start = 1'b1;
              state_next = ST_WALK;
            end
            CMD_READ: begin
              cmd.read_start = 1'b1;
              state_next = ST_READ;
            end
            default: finish_now = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        if (stat.walk_done) state_next = ST_POST;
      end
      ST_READ: begin
        if (stat.read_done) state_next = ST_POST;
      end
      ST_POST: begin
        if (!out_full || out_take) begin
          finish_now = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      started <= 1'b0;
    end else begin
      state <= state_next;
      started <= started_next;
    end
  end
endmodule

@@ rtl/ogsu_dp.sv @@
// Datapath: grid and beam memories, the cell walker, CORDIC bearing and cell update.
module ogsu_dp import ogsu_pkg::*; #(
  parameter int GridRows = GridRowsDef,
  parameter int GridCols = GridColsDef,
  parameter int BeamCount = BeamCountDef
) (
  input  logic               clk,
  input  logic               rst,
  input  ogsu_cmd_t          cmd,
  output ogsu_stat_t         stat,
  input  logic               accept,
  input  logic [1:0]         command,
  input  logic [8:0]         beam_index,
  input  logic [15:0]        beam_range,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        heading_angle,
  input  logic [15:0]        max_range,
  input  logic [7:0]         cell_row,
  input  logic [7:0]         cell_col,
  input  logic signed [15:0] free_increment,
  input  logic signed [15:0] occupied_increment,
  input  logic signed [15:0] prior_value,
  input  logic [9:0]         half_thickness,
  input  logic [7:0]         origin_col,
  input  logic [7:0]         origin_row,
  output logic signed [15:0] read_value
);
  localparam int RowBits = $clog2(GridRows);
  localparam int ColBits = $clog2(GridCols);
  localparam int CellBits = RowBits + ColBits;
  localparam int Cells = 1 << CellBits;
  localparam int BeamBits = $clog2(BeamCount);
  localparam int Lat = CordicSteps + 6;
  localparam int CntBits = $clog2(Lat + 1);

  // Robot pose and update range.
  logic signed [15:0] robot_x, robot_y;
  logic [15:0]        robot_heading;
  logic [31:0]        max2;

  always_ff @(posedge clk) begin
    if (rst) begin
      robot_x <= '0;
      robot_y <= '0;
      robot_heading <= '0;
    end else if (accept && command == CMD_POSE) begin
      robot_x <= pos_x;
      robot_y <= pos_y;
      robot_heading <= heading_angle;
    end
  end

  // The squared range is held for the whole walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      max2 <= '0;
    end else if (accept && command == CMD_UPDATE) begin
      max2 <= 32'(max_range) * 32'(max_range);
    end
  end

  // Beam range table.
  logic                beam_we;
  logic [BeamBits-1:0] beam_raddr;
  logic [15:0]         beam_rdata;
  assign beam_we = accept && command == CMD_LOAD && ({23'd0, beam_index} < BeamCount);

  ogsu_ram #(.Width(16), .Depth(BeamCount)) u_beam (
    .clk(clk), .we(beam_we), .waddr(beam_index[BeamBits-1:0]), .wdata(beam_range),
    .raddr(beam_raddr), .rdata(beam_rdata)
  );

  // Grid memory.
  logic                grid_we;
  logic [CellBits-1:0] grid_waddr, grid_raddr;
  logic [15:0]         grid_wdata, grid_rdata;

  ogsu_ram #(.Width(16), .Depth(Cells)) u_grid (
    .clk(clk), .we(grid_we), .waddr(grid_waddr), .wdata(grid_wdata),
    .raddr(grid_raddr), .rdata(grid_rdata)
  );

  // Walker: clearing sweep and the update walk share the cell counter.
  logic                clearing, walking, issuing, read_wait;
  logic [CellBits-1:0] cell_cnt;
  logic [CntBits-1:0]  drain;
  logic [1:0]          read_cnt;
  logic                read_ok;
  logic [CellBits-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b0;
      walking <= 1'b0;
      issuing <= 1'b0;
      read_wait <= 1'b0;
      cell_cnt <= '0;
      drain <= '0;
      read_cnt <= '0;
    end else begin
      if (cmd.clear_start) begin
        clearing <= 1'b1;
        cell_cnt <= '0;
      end else if (clearing) begin
        cell_cnt <= cell_cnt + 1'b1;
        if (cell_cnt == CellBits'(Cells - 1)) clearing <= 1'b0;
      end
      if (cmd.walk_start) begin
        walking <= 1'b1;
        issuing <= 1'b1;
        cell_cnt <= '0;
        drain <= CntBits'(Lat);
      end else if (walking) begin
        if (issuing) begin
          cell_cnt <= cell_cnt + 1'b1;
          if (cell_cnt == CellBits'(Cells - 1)) issuing <= 1'b0;
        end else if (drain != '0) begin
          drain <= drain - 1'b1;
        end else begin
          walking <= 1'b0;
        end
      end
      if (cmd.read_start) begin
        read_wait <= 1'b1;
        read_cnt <= '0;
      end else if (read_wait) begin
        read_cnt <= read_cnt + 1'b1;
        if (read_cnt == 2'd1) read_wait <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_start) begin
      read_ok <= ({24'd0, cell_row} < GridRows) && ({24'd0, cell_col} < GridCols);
      rd_addr <= {RowBits'(cell_row), ColBits'(cell_col)};
    end
  end

  assign stat.clear_done = !clearing;
  assign stat.walk_done = walking && !issuing && drain == '0;
  assign stat.read_done = read_wait && read_cnt == 2'd1;

  always_ff @(posedge clk) begin
    if (read_wait && read_cnt == 2'd1) begin
      read_value <= read_ok ? grid_rdata : 16'sd0;
    end
  end

  // Stage 0: cell position and offset from the robot.
  logic                 s0_v;
  logic [CellBits-1:0]  s0_addr;
  logic signed [19:0]   s0_dx, s0_dy;
  logic [RowBits-1:0]   cur_row;
  logic [ColBits-1:0]   cur_col;
  logic                 cur_ok;
  assign cur_row = cell_cnt[CellBits-1:ColBits];
  assign cur_col = cell_cnt[ColBits-1:0];
  assign cur_ok = ({{(32-RowBits){1'b0}}, cur_row} < GridRows) &&
                  ({{(32-ColBits){1'b0}}, cur_col} < GridCols);

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else s0_v <= walking && issuing && cur_ok;
    s0_addr <= cell_cnt;
    s0_dx <= (($signed({9'd0, cur_col}) - $signed({12'd0, origin_col})) <<< 4)
             - 20'(robot_x);
    s0_dy <= (($signed({9'd0, cur_row}) - $signed({12'd0, origin_row})) <<< 4)
             - 20'(robot_y);
  end

  // Stage 1: squared distance and CORDIC pre-rotation.
  logic               s1_v;
  logic [CellBits-1:0] s1_addr;
  logic [39:0]        s1_d2;
  logic signed [22:0] s1_x, s1_y;
  logic [15:0]        s1_ang;
  logic               s1_zero;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else s1_v <= s0_v;
    s1_addr <= s0_addr;
    s1_d2 <= 40'(s0_dx * s0_dx) + 40'(s0_dy * s0_dy);
    s1_zero <= (s0_dx == 0) && (s0_dy == 0);
    if (s0_dx < 0) begin
      s1_x <= -23'(s0_dx);
      s1_y <= -23'(s0_dy);
      s1_ang <= 16'd32768;
    end else begin
      s1_x <= 23'(s0_dx);
      s1_y <= 23'(s0_dy);
      s1_ang <= 16'd0;
    end
  end

  // CORDIC stages, one rotation per register.
  logic                c_v   [CordicSteps+1];
  logic [CellBits-1:0] c_addr[CordicSteps+1];
  logic [39:0]         c_d2  [CordicSteps+1];
  logic signed [22:0]  c_x   [CordicSteps+1];
  logic signed [22:0]  c_y   [CordicSteps+1];
  logic [15:0]         c_ang [CordicSteps+1];
  logic                c_zero[CordicSteps+1];

  assign c_v[0] = s1_v;
  assign c_addr[0] = s1_addr;
  assign c_d2[0] = s1_d2;
  assign c_x[0] = s1_x;
  assign c_y[0] = s1_y;
  assign c_ang[0] = s1_ang;
  assign c_zero[0] = s1_zero;

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) c_v[k+1] <= 1'b0;
      else c_v[k+1] <= c_v[k];
      c_addr[k+1] <= c_addr[k];
      c_d2[k+1] <= c_d2[k];
      c_zero[k+1] <= c_zero[k];
      if (c_y[k] > 0) begin
        c_x[k+1] <= c_x[k] + (c_y[k] >>> k);
        c_y[k+1] <= c_y[k] - (c_x[k] >>> k);
        c_ang[k+1] <= c_ang[k] + atan_entry(4'(k));
      end else begin
        c_x[k+1] <= c_x[k] - (c_y[k] >>> k);
        c_y[k+1] <= c_y[k] + (c_x[k] >>> k);
        c_ang[k+1] <= c_ang[k] - atan_entry(4'(k));
      end
    end
  end

  // Stage A: range gate and beam selection.
  logic                a_v;
  logic [CellBits-1:0] a_addr;
  logic [39:0]         a_d2;
  logic [15:0]         rel;
  logic [24:0]         beam_prod;
  logic [8:0]          beam_sel;
  assign rel = (c_zero[CordicSteps] ? 16'd0 : c_ang[CordicSteps]) - robot_heading;
  assign beam_prod = 25'(rel) * 25'd360;
  assign beam_sel = (beam_prod[24:16] >= 9'(BeamCount)) ? 9'(BeamCount - 1)
                                                        : beam_prod[24:16];
  assign beam_raddr = BeamBits'(beam_sel);

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else a_v <= c_v[CordicSteps] && (c_d2[CordicSteps] < {8'd0, max2});
    a_addr <= c_addr[CordicSteps];
    a_d2 <= c_d2[CordicSteps];
  end

  // Stage B: band limits from the beam range.
  logic                b_v;
  logic [CellBits-1:0] b_addr;
  logic [39:0]         b_d2;
  logic [16:0]         lo, hi;
  logic                lo_ok;
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else b_v <= a_v;
    b_addr <= a_addr;
    b_d2 <= a_d2;
    lo_ok <= {1'b0, beam_rdata} > {7'd0, half_thickness};
    lo <= {1'b0, beam_rdata} - {7'd0, half_thickness};
    hi <= {1'b0, beam_rdata} + {7'd0, half_thickness};
  end

  // Stage C: squares of the band limits.
  logic                cc_v;
  logic [CellBits-1:0] cc_addr;
  logic [39:0]         cc_d2;
  logic [33:0]         lo2, hi2;
  logic                cc_lo_ok;
  always_ff @(posedge clk) begin
    if (rst) cc_v <= 1'b0;
    else cc_v <= b_v;
    cc_addr <= b_addr;
    cc_d2 <= b_d2;
    cc_lo_ok <= lo_ok;
    lo2 <= 34'(lo) * 34'(lo);
    hi2 <= 34'(hi) * 34'(hi);
  end

  // Stage D: classification; grid read issued.
  logic                d_v;
  logic [CellBits-1:0] d_addr;
  logic signed [15:0]  d_inc;
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else d_v <= cc_v && (cc_lo_ok && cc_d2 < {6'd0, lo2} || cc_d2 < {6'd0, hi2});
    d_addr <= cc_addr;
    d_inc <= (cc_lo_ok && cc_d2 < {6'd0, lo2}) ? free_increment : occupied_increment;
  end

  // Stage E: write back. Cells are visited once, so no forwarding is needed.
  logic                e_v;
  logic [CellBits-1:0] e_addr;
  logic signed [15:0]  e_inc;
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else e_v <= d_v;
    e_addr <= d_addr;
    e_inc <= d_inc;
  end

  always_comb begin
    grid_raddr = d_v ? d_addr : rd_addr;
    grid_we = clearing || e_v;
    grid_waddr = clearing ? cell_cnt : e_addr;
    grid_wdata = clearing ? 16'd0
               : sat16(18'($signed(grid_rdata)) + 18'(e_inc) - 18'(prior_value));
  end
endmodule

@@ rtl/occupancy_grid_scan_update.sv @@
// Top level of the occupancy grid scan update block.
// The block keeps a log-odds occupancy grid and a 360-entry beam range table.
// Requests arrive on the in channel (in_valid, in_stall driven by the block)
// with a command: load beam, set pose, update map or read cell. Each request
// gives exactly one result on the out channel (out_valid, out_stall from the
// receiver) carrying cell_value and an echo of the command.
// Configuration registers are written through cfg_valid, cfg_ready, cfg_index
// and cfg_data. The user must write them only while the block is idle; the
// block does not enforce this. Load beam and set pose give their result in
// the cycle after acceptance. A read cell reads the grid memory and returns
// the value. An update walks the whole grid one cell per cycle through a
// pipelined distance, CORDIC bearing and classification path and ends once
// that path has drained. After reset the grid is cleared by a sweep of one
// cell a cycle, during which no request is accepted. A result waits in the
// output register while the receiver stalls; the next request is taken once
// that register can be freed in the same cycle.
`include "occupancy_grid_scan_update_defines.svh"
module occupancy_grid_scan_update import ogsu_pkg::*; #(
  parameter int GRID_ROWS = GridRowsDef,
  parameter int GRID_COLS = GridColsDef,
  parameter int BEAM_COUNT = BeamCountDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [8:0]         beam_index,
  input  logic [15:0]        beam_range,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        heading_angle,
  input  logic [15:0]        max_range,
  input  logic [7:0]         cell_row,
  input  logic [7:0]         cell_col,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] cell_value,
  output logic [1:0]         done_command,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  logic signed [15:0] free_increment, occupied_increment, prior_value;
  logic [9:0]         half_thickness;
  logic [7:0]         origin_col, origin_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_increment <= -16'sd1420;
      occupied_increment <= 16'sd1420;
      prior_value <= '0;
      half_thickness <= 10'd24;
      origin_col <= 8'd20;
      origin_row <= 8'd190;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FREE: free_increment <= cfg_data;
        REG_OCC: occupied_increment <= cfg_data;
        REG_PRIOR: prior_value <= cfg_data;
        REG_HALF: half_thickness <= cfg_data[9:0];
        REG_OCOL: origin_col <= cfg_data[7:0];
        REG_OROW: origin_row <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ogsu_cmd_t          cmd;
  ogsu_stat_t         stat;
  logic               accept, finish_now, busy, out_take;
  logic [1:0]         held_cmd;
  logic signed [15:0] read_value;

  assign out_take = out_valid && !out_stall;
  assign in_stall = !(!busy && (!out_valid || out_take));

  ogsu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_command(command),
    .out_full(out_valid), .out_take(out_take), .stat(stat), .cmd(cmd),
    .accept(accept), .finish_now(finish_now), .busy(busy)
  );

  ogsu_dp #(.GridRows(GRID_ROWS), .GridCols(GRID_COLS), .BeamCount(BEAM_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .accept(accept), .command(command),
    .beam_index(beam_index), .beam_range(beam_range), .pos_x(pos_x), .pos_y(pos_y),
    .heading_angle(heading_angle), .max_range(max_range), .cell_row(cell_row),
    .cell_col(cell_col), .free_increment(free_increment),
    .occupied_increment(occupied_increment), .prior_value(prior_value),
    .half_thickness(half_thickness), .origin_col(origin_col), .origin_row(origin_row),
    .read_value(read_value)
  );

  always_ff @(posedge clk) begin
    if (accept) held_cmd <= command;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_now) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
    if (finish_now) begin
      if (accept) begin
        done_command <= command;
        cell_value <= '0;
      end else begin
        done_command <= held_cmd;
        cell_value <= (held_cmd == CMD_READ) ? read_value : 16'sd0;
      end
    end
  end

  `OGSU_ASSERT_NOW(a_accept_idle, clk, rst, accept, !busy)
  `OGSU_ASSERT_NOW(a_finish_room, clk, rst, finish_now, !out_valid || out_take)
  `OGSU_ASSERT_NEXT(a_walk_busy, clk, rst, cmd.walk_start, busy)
endmodule
